/* rtl/key_binding_match_table_macros.svh */
// Assertion macros for the key binding match table.
// Depends on nothing; included by the files that carry assertions.
`ifndef KEY_BINDING_MATCH_TABLE_MACROS_SVH
`define KEY_BINDING_MATCH_TABLE_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked at every rising edge outside reset.
`define KBMT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define KBMT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KBMT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define KBMT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/kbmt_pkg.sv */
// Shared types and constants of the key binding match table.
// No dependencies; used by the request interface, controller, datapath and top level.
package kbmt_pkg;

    // Fixed field widths of the binding key
    localparam int MODE_BITS = 2;
    localparam int MODS_BITS = 8;

    // Operation codes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_BIND   = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic start;         // latch request fields, restart the scan
        logic scan;          // issue one read and compare the previous one
        logic read_last;     // read the last valid entry
        logic write_update;  // rewrite the matched slot with the new command
        logic write_append;  // write a new entry at the count
        logic write_move;    // copy the last entry into the matched slot
        logic set_full;      // flag a refused append
        logic load_out;      // load the result register
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic op_bind;    // latched operation is a bind
        logic cmd_zero;   // latched command is the none command
        logic match;      // compared entry matches the key this cycle
        logic scan_miss;  // scan finished with no match
        logic hit;        // a match was recorded
        logic full;       // table holds every entry it can
        logic out_free;   // result register can take a new beat
    } dp_status_t;

endpackage

/* rtl/kbmt_req_if.sv */
// Request channel of the key binding match table: valid/ready plus request fields.
// Depends on kbmt_pkg.
interface kbmt_req_if #(
    parameter int KEY_BITS     = 8,
    parameter int COMMAND_BITS = 6
);
    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic [kbmt_pkg::MODE_BITS-1:0] edit_mode;
    logic [KEY_BITS-1:0]            key_code;
    logic [kbmt_pkg::MODS_BITS-1:0] modifiers;
    logic [COMMAND_BITS-1:0]        command;

    modport source (
        output valid, operation, edit_mode, key_code, modifiers, command,
        input  ready
    );

    modport sink (
        input  valid, operation, edit_mode, key_code, modifiers, command,
        output ready
    );
endinterface

/* rtl/kbmt_rsp_if.sv */
// Response channel of the key binding match table: valid/ready plus result fields.
// No dependencies beyond its parameters.
interface kbmt_rsp_if #(
    parameter int COMMAND_BITS = 6
);
    logic                    valid;
    logic                    ready;
    logic [COMMAND_BITS-1:0] found_command;
    logic                    hit;
    logic                    table_full;

    modport source (
        output valid, found_command, hit, table_full,
        input  ready
    );

    modport sink (
        input  valid, found_command, hit, table_full,
        output ready
    );
endinterface

/* rtl/kbmt_ctrl.sv */
// Controller state machine of the key binding match table.
// Depends on kbmt_pkg for the command and status structs.
module kbmt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  kbmt_pkg::dp_status_t status,
    output kbmt_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_ACT  = 5'b00100,
        ST_MOVE = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.match || status.scan_miss)
                begin
                    state_next = ST_ACT;
                end
            end
            ST_ACT:
            begin
                state_next = ST_DONE;
                if (status.op_bind)
                begin
                    if (status.hit)
                    begin
                        if (status.cmd_zero)
                        begin
                            // remove: fetch the last entry, then move it
                            cmd.read_last = 1'b1;
                            state_next    = ST_MOVE;
                        end
                        else
                        begin
                            cmd.write_update = 1'b1;
                        end
                    end
                    else if (!status.cmd_zero)
                    begin
                        if (status.full)
                        begin
                            cmd.set_full = 1'b1;
                        end
                        else
                        begin
                            cmd.write_append = 1'b1;
                        end
                    end
                end
            end
            ST_MOVE:
            begin
                cmd.write_move = 1'b1;
                state_next     = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/kbmt_dp.sv */
// Datapath of the key binding match table: binding memory, scan compare,
// entry count and result register. Depends on kbmt_pkg.
module kbmt_dp #(
    parameter int TABLE_ENTRIES = 64,
    parameter int KEY_BITS      = 8,
    parameter int COMMAND_BITS  = 6
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  kbmt_pkg::ctrl_cmd_t            cmd,
    output kbmt_pkg::dp_status_t           status,
    input  logic                           operation,
    input  logic [kbmt_pkg::MODE_BITS-1:0] edit_mode,
    input  logic [KEY_BITS-1:0]            key_code,
    input  logic [kbmt_pkg::MODS_BITS-1:0] modifiers,
    input  logic [COMMAND_BITS-1:0]        command,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [COMMAND_BITS-1:0]        found_command,
    output logic                           hit,
    output logic                           table_full
);

    localparam int TAG_W   = kbmt_pkg::MODE_BITS + KEY_BITS + kbmt_pkg::MODS_BITS;
    localparam int ENTRY_W = TAG_W + COMMAND_BITS;
    localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);

    // Binding memory, valid below the count only
    logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];

    // Latched request
    logic                    op_reg;
    logic [TAG_W-1:0]        tag_reg;
    logic [COMMAND_BITS-1:0] cmd_reg;

    // Scan and match state
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        scan_idx_reg;
    logic                    rd_vld_reg;
    logic [IDX_W-1:0]        rd_idx_reg;
    logic [ENTRY_W-1:0]      rdata_reg;
    logic                    hit_reg;
    logic [IDX_W-1:0]        slot_reg;
    logic [COMMAND_BITS-1:0] found_reg;
    logic                    full_reg;

    // Result register
    logic                    out_valid_reg;
    logic [COMMAND_BITS-1:0] out_cmd_reg;
    logic                    out_hit_reg;
    logic                    out_full_reg;

    logic                    cmp_hit;
    logic                    issue;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic [CNT_W-1:0]        last_cnt;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [ENTRY_W-1:0]      wr_data;

    // Scan compare and read issue
    assign cmp_hit  = rd_vld_reg && (rdata_reg[ENTRY_W-1:COMMAND_BITS] == tag_reg);
    assign issue    = cmd.scan && !cmp_hit && (scan_idx_reg < count_reg);
    assign last_cnt = count_reg - CNT_W'(1);
    assign rd_en    = issue || cmd.read_last;
    assign rd_addr  = cmd.read_last ? last_cnt[IDX_W-1:0] : scan_idx_reg[IDX_W-1:0];

    // Write port select
    always_comb
    begin
        wr_en   = cmd.write_update || cmd.write_append || cmd.write_move;
        wr_addr = slot_reg;
        wr_data = {tag_reg, cmd_reg};
        if (cmd.write_append)
        begin
            wr_addr = count_reg[IDX_W-1:0];
        end
        else if (cmd.write_move)
        begin
            wr_data = rdata_reg;
        end
    end

    // Memory with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Request and match payload
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg    <= operation;
            tag_reg   <= {edit_mode, key_code, modifiers};
            cmd_reg   <= command;
            found_reg <= '0;
        end
        if (issue)
        begin
            rd_idx_reg <= scan_idx_reg[IDX_W-1:0];
        end
        if (cmd.scan && cmp_hit)
        begin
            slot_reg  <= rd_idx_reg;
            found_reg <= rdata_reg[COMMAND_BITS-1:0];
        end
    end

    // Control state: count, scan pointer, flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            scan_idx_reg <= '0;
            rd_vld_reg   <= 1'b0;
            hit_reg      <= 1'b0;
            full_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                scan_idx_reg <= '0;
                rd_vld_reg   <= 1'b0;
                hit_reg      <= 1'b0;
                full_reg     <= 1'b0;
            end
            else
            begin
                rd_vld_reg <= issue;
                if (issue)
                begin
                    scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                end
                if (cmd.scan && cmp_hit)
                begin
                    hit_reg <= 1'b1;
                end
                if (cmd.set_full)
                begin
                    full_reg <= 1'b1;
                end
            end
            if (cmd.write_append)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.write_move)
            begin
                count_reg <= last_cnt;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_cmd_reg  <= (op_reg == kbmt_pkg::OP_BIND) ? '0 : found_reg;
            out_hit_reg  <= hit_reg;
            out_full_reg <= full_reg;
        end
    end

    // Status to the controller
    always_comb
    begin
        status           = '0;
        status.op_bind   = (op_reg == kbmt_pkg::OP_BIND);
        status.cmd_zero  = (cmd_reg == '0);
        status.match     = cmp_hit;
        status.scan_miss = !cmp_hit && !(scan_idx_reg < count_reg);
        status.hit       = hit_reg;
        status.full      = (count_reg == CNT_W'(TABLE_ENTRIES));
        status.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid     = out_valid_reg;
    assign found_command = out_cmd_reg;
    assign hit           = out_hit_reg;
    assign table_full    = out_full_reg;

endmodule

/* rtl/key_binding_match_table.sv */
// Key binding match table, top level. A beat scans the entries up to the match
// or, on a miss, to the count, then for a bind updates, appends, refuses an
// append or removes; a remove moves the last entry into the matched slot. The
// binding memory has one read port and the scan compares one entry per cycle.
// One request beat is in work at a time; the next is taken once the result is
// in the output register. Reset empties the table (count zero) at once.
`include "key_binding_match_table_macros.svh"

module key_binding_match_table #(
    parameter int TABLE_ENTRIES = 64,
    parameter int KEY_BITS      = 8,
    parameter int COMMAND_BITS  = 6
) (
    input logic       clk,
    input logic       rst_n,
    kbmt_req_if.sink  req,
    kbmt_rsp_if.source rsp
);

    kbmt_pkg::ctrl_cmd_t  cmd;
    kbmt_pkg::dp_status_t status;

    // Controller
    kbmt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath
    kbmt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .KEY_BITS      (KEY_BITS),
        .COMMAND_BITS  (COMMAND_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .operation     (req.operation),
        .edit_mode     (req.edit_mode),
        .key_code      (req.key_code),
        .modifiers     (req.modifiers),
        .command       (req.command),
        .out_ready     (rsp.ready),
        .out_valid     (rsp.valid),
        .found_command (rsp.found_command),
        .hit           (rsp.hit),
        .table_full    (rsp.table_full)
    );

    // A refused append only happens on a miss
    `KBMT_ASSERT_IMP(a_full_is_miss, clk, rst_n, rsp.valid && rsp.table_full, !rsp.hit, "table_full with hit")
    // A nonzero command comes back only from a matched entry
    `KBMT_ASSERT_IMP(a_found_needs_hit, clk, rst_n, rsp.valid && (rsp.found_command != '0), rsp.hit, "command without hit")
    // At most one memory write per cycle
    `KBMT_ASSERT_IMP(a_one_write, clk, rst_n, 1'b1, $onehot0({cmd.write_update, cmd.write_append, cmd.write_move}), "multiple writes")
    // After a request beat the block is busy
    `KBMT_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, req.valid && req.ready, !req.ready, "ready after beat")

endmodule
